[design/mald_pkg.sv]
// ----------------------------------------------------------------------------
// mald_pkg
// Shared constants, register and format codes, and status types for the
// mean absolute level decimator.
// ----------------------------------------------------------------------------
package mald_pkg;

  // Default sizing of the block.
  localparam int MaxChannels = 8;
  localparam int MaxBlock    = 4096;
  localparam int FracBits    = 8;

  // Fixed widths of the ports.
  localparam int SampleW   = 32;
  localparam int LevelW    = 40;
  localparam int FmtW      = 2;
  localparam int ChCfgW    = 4;
  localparam int BkCfgW    = 13;
  localparam int CfgW      = 13;
  localparam int CfgIdxW   = 2;

  // Depth of the queue between the accumulator and the divider.
  localparam int JobDepth  = 2;

  // Register values after reset.
  localparam logic [FmtW-1:0]   FmtReset = 2'd1;
  localparam logic [ChCfgW-1:0] ChReset  = 4'd2;
  localparam logic [BkCfgW-1:0] BkReset  = 13'd10;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SAMPLE_FORMAT = 2'd0,
    REG_CHANNEL_COUNT = 2'd1,
    REG_BLOCK_SIZE    = 2'd2
  } cfg_reg_e;

  typedef enum logic [FmtW-1:0] {
    FMT_U8  = 2'd0,
    FMT_S16 = 2'd1,
    FMT_S32 = 2'd2
  } sample_fmt_e;

  // Status of the divider as seen by the top level.
  typedef struct packed {
    logic idle;
    logic finish;
  } div_status_t;

endpackage

[design/mean_abs_level_decimator_unit.sv]
// ----------------------------------------------------------------------------
// mean_abs_level_decimator_unit: mean absolute level of interleaved audio
// Throughput: one sample per cycle while full is low; the bit-serial divider
// works on one job at a time and cannot start the next before it is done, and its job queue holds two.
// Reset: asynchronous; clears sums, counters and queues, registers to 1, 2, 10.
// ----------------------------------------------------------------------------
module mean_abs_level_decimator_unit #(
  parameter int MAX_CHANNELS = mald_pkg::MaxChannels,
  parameter int MAX_BLOCK    = mald_pkg::MaxBlock,
  parameter int FRAC_BITS    = mald_pkg::FracBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Sample side: an item is taken when push is high and full is low.
  input  logic                          push,
  output logic                          full,
  input  logic [mald_pkg::SampleW-1:0]  sample_bits_i,
  // Level side: the oldest level is shown while empty is low.
  output logic                          empty,
  input  logic                          pop,
  output logic [mald_pkg::LevelW-1:0]   level_o,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [mald_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mald_pkg::CfgW-1:0]     cfg_data_i
);

  localparam int ChW    = $clog2(MAX_CHANNELS + 1);
  localparam int BkW    = $clog2(MAX_BLOCK + 1);
  localparam int FrameW = mald_pkg::SampleW + $clog2(MAX_CHANNELS);
  localparam int BlkW   = FrameW + $clog2(MAX_BLOCK);
  localparam int DivW   = ChW + BkW;
  localparam int JobW   = BlkW + DivW;

  logic [mald_pkg::FmtW-1:0]   fmt_q;
  logic [mald_pkg::ChCfgW-1:0] ch_q;
  logic [mald_pkg::BkCfgW-1:0] bk_q;

  logic                  job_push;
  logic                  job_full;
  logic                  job_empty;
  logic                  job_pop;
  logic [BlkW-1:0]       job_sum;
  logic [DivW-1:0]       job_div;
  logic [JobW-1:0]       job_head;
  mald_pkg::div_status_t div_st;

  // Configuration registers. The user must write them only while the block is idle
  // (not enforced), since the front end samples them directly; an unused index is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= mald_pkg::FmtReset;
      ch_q  <= mald_pkg::ChReset;
      bk_q  <= mald_pkg::BkReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        mald_pkg::REG_SAMPLE_FORMAT: fmt_q <= cfg_data_i[mald_pkg::FmtW-1:0];
        mald_pkg::REG_CHANNEL_COUNT: ch_q  <= cfg_data_i[mald_pkg::ChCfgW-1:0];
        mald_pkg::REG_BLOCK_SIZE:    bk_q  <= cfg_data_i[mald_pkg::BkCfgW-1:0];
        default: ;
      endcase
    end
  end

  // The front end decodes each sample and keeps the frame and block sums.
  // It only holds off new samples when a finished block cannot enter the
  // full job queue; otherwise it takes a sample every cycle.
  mald_front #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_BLOCK    (MAX_BLOCK)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .sample_i   (sample_bits_i),
    .fmt_i      (fmt_q),
    .ch_cfg_i   (ch_q),
    .bk_cfg_i   (bk_q),
    .stall_o    (full),
    .job_push_o (job_push),
    .job_sum_o  (job_sum),
    .job_div_o  (job_div),
    .job_full_i (job_full)
  );

  // Each job carries the block sum and the divisor that held when the block
  // closed, so later configuration cannot disturb a level in flight.
  mald_job_fifo #(
    .DATA_W (JobW),
    .DEPTH  (mald_pkg::JobDepth)
  ) u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  ({job_sum, job_div}),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (job_head),
    .empty_o (job_empty)
  );

  // The back end divides the block sum, scaled by the fraction bits, by the
  // channel count times the block size, and holds the level for the reader.
  // It may start the next division while a level still waits to be taken.
  mald_divider #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_BLOCK    (MAX_BLOCK),
    .FRAC_BITS    (FRAC_BITS)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!job_empty),
    .job_sum_i   (job_head[JobW-1:DivW]),
    .job_div_i   (job_head[DivW-1:0]),
    .job_pop_o   (job_pop),
    .res_pop_i   (pop),
    .res_empty_o (empty),
    .level_o     (level_o),
    .status_o    (div_st)
  );

  // A finished block is never offered to a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push |-> !job_full)
    else $error("job pushed into a full queue");

  // The divider takes a job only when one is waiting and it is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop |-> (!job_empty && div_st.idle))
    else $error("divider took a job it could not accept");

  // A level appears on the output only when a division has just completed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(empty) |-> $past(div_st.finish))
    else $error("level shown without a finished division");

endmodule

[design/mald_front.sv]
// ----------------------------------------------------------------------------
// mald_front
// Decodes samples, sums channels into frames and frame magnitudes into
// blocks, and hands each finished block to the divider queue.
// ----------------------------------------------------------------------------
module mald_front #(
  parameter int MAX_CHANNELS = mald_pkg::MaxChannels,
  parameter int MAX_BLOCK    = mald_pkg::MaxBlock,
  localparam int ChW    = $clog2(MAX_CHANNELS + 1),
  localparam int BkW    = $clog2(MAX_BLOCK + 1),
  localparam int FrameW = mald_pkg::SampleW + $clog2(MAX_CHANNELS),
  localparam int BlkW   = FrameW + $clog2(MAX_BLOCK),
  localparam int DivW   = ChW + BkW
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  logic [mald_pkg::SampleW-1:0]  sample_i,
  input  logic [mald_pkg::FmtW-1:0]     fmt_i,
  input  logic [mald_pkg::ChCfgW-1:0]   ch_cfg_i,
  input  logic [mald_pkg::BkCfgW-1:0]   bk_cfg_i,
  output logic                          stall_o,
  output logic                          job_push_o,
  output logic [BlkW-1:0]               job_sum_o,
  output logic [DivW-1:0]               job_div_o,
  input  logic                          job_full_i
);

  logic signed [FrameW-1:0] smp;
  logic signed [FrameW-1:0] fsum_nxt;
  logic signed [FrameW-1:0] frame_sum_q;
  logic signed [FrameW-1:0] pend_sum_q;
  logic        [ChW-1:0]    pos_q;
  logic        [BkW-1:0]    fcnt_q;
  logic        [BlkW-1:0]   block_sum_q;
  logic        [BlkW-1:0]   blk_ext;
  logic        [BlkW-1:0]   blk_nxt;
  logic        [DivW-1:0]   pend_div_q;
  logic                     pend_vld_q;
  logic                     pend_last_q;
  logic        [ChW-1:0]    chans;
  logic        [BkW-1:0]    frames;
  logic                     frame_end;
  logic                     block_end;
  logic                     acc;
  logic                     pend_go;

  always_comb begin
    unique case (fmt_i)
      mald_pkg::FMT_U8:  smp = FrameW'($signed({1'b0, sample_i[7:0]}));
      mald_pkg::FMT_S16: smp = FrameW'($signed(sample_i[15:0]));
      mald_pkg::FMT_S32: smp = FrameW'($signed(sample_i));
      default:           smp = '0;
    endcase
  end

  always_comb begin
    if (ch_cfg_i == '0) begin
      chans = ChW'(1);
    end else if (32'(ch_cfg_i) > MAX_CHANNELS) begin
      chans = ChW'(MAX_CHANNELS);
    end else begin
      chans = ChW'(ch_cfg_i);
    end
    if (bk_cfg_i == '0) begin
      frames = BkW'(1);
    end else if (32'(bk_cfg_i) > MAX_BLOCK) begin
      frames = BkW'(MAX_BLOCK);
    end else begin
      frames = BkW'(bk_cfg_i);
    end
  end

  assign fsum_nxt  = frame_sum_q + smp;
  assign frame_end = ((ChW + 1)'(pos_q) + (ChW + 1)'(1)) >= (ChW + 1)'(chans);
  assign block_end = ((BkW + 1)'(fcnt_q) + (BkW + 1)'(1)) >= (BkW + 1)'(frames);

  // A finished frame waits in the pending stage, where its magnitude is
  // folded into the block sum by one add or subtract.
  assign stall_o = pend_vld_q && pend_last_q && job_full_i;
  assign acc     = push_i && !stall_o;
  assign pend_go = pend_vld_q && !stall_o;

  assign blk_ext = BlkW'(pend_sum_q);
  assign blk_nxt = pend_sum_q[FrameW-1] ? (block_sum_q - blk_ext)
                                        : (block_sum_q + blk_ext);

  assign job_push_o = pend_go && pend_last_q;
  assign job_sum_o  = blk_nxt;
  assign job_div_o  = pend_div_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_sum_q <= '0;
      pos_q       <= '0;
      fcnt_q      <= '0;
      block_sum_q <= '0;
      pend_vld_q  <= 1'b0;
      pend_last_q <= 1'b0;
    end else begin
      if (pend_go) begin
        block_sum_q <= pend_last_q ? '0 : blk_nxt;
      end
      // A new frame may enter the pending stage in the cycle that empties it.
      if (acc && frame_end) begin
        pend_vld_q <= 1'b1;
      end else if (pend_go) begin
        pend_vld_q <= 1'b0;
      end
      if (acc) begin
        if (frame_end) begin
          frame_sum_q <= '0;
          pos_q       <= '0;
          pend_last_q <= block_end;
          fcnt_q      <= block_end ? '0 : fcnt_q + BkW'(1);
        end else begin
          frame_sum_q <= fsum_nxt;
          pos_q       <= pos_q + ChW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && frame_end) begin
      pend_sum_q <= fsum_nxt;
      pend_div_q <= DivW'(chans) * DivW'(frames);
    end
  end

endmodule

[design/mald_job_fifo.sv]
// ----------------------------------------------------------------------------
// mald_job_fifo
// Short queue of finished blocks between the accumulator and the divider.
// ----------------------------------------------------------------------------
module mald_job_fifo #(
  parameter int DATA_W = 64,
  parameter int DEPTH  = mald_pkg::JobDepth,
  localparam int PtrW  = $clog2(DEPTH),
  localparam int CntW  = $clog2(DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic [DATA_W-1:0] data_o,
  output logic              empty_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q;
  logic [PtrW-1:0]   rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[design/mald_divider.sv]
// ----------------------------------------------------------------------------
// mald_divider
// Restoring divider, one quotient bit per cycle, followed by the result
// register that holds the level until it is taken.
// ----------------------------------------------------------------------------
module mald_divider #(
  parameter int MAX_CHANNELS = mald_pkg::MaxChannels,
  parameter int MAX_BLOCK    = mald_pkg::MaxBlock,
  parameter int FRAC_BITS    = mald_pkg::FracBits,
  localparam int ChW    = $clog2(MAX_CHANNELS + 1),
  localparam int BkW    = $clog2(MAX_BLOCK + 1),
  localparam int FrameW = mald_pkg::SampleW + $clog2(MAX_CHANNELS),
  localparam int BlkW   = FrameW + $clog2(MAX_BLOCK),
  localparam int DivW   = ChW + BkW,
  localparam int QuoW   = BlkW + FRAC_BITS,
  localparam int CntW   = $clog2(QuoW + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         job_valid_i,
  input  logic [BlkW-1:0]              job_sum_i,
  input  logic [DivW-1:0]              job_div_i,
  output logic                         job_pop_o,
  input  logic                         res_pop_i,
  output logic                         res_empty_o,
  output logic [mald_pkg::LevelW-1:0]  level_o,
  output mald_pkg::div_status_t        status_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } div_state_e;

  div_state_e                  state_q;
  logic [QuoW-1:0]             quo_q;
  logic [DivW-1:0]             rem_q;
  logic [DivW-1:0]             dvs_q;
  logic [CntW-1:0]             cnt_q;
  logic                        res_vld_q;
  logic [mald_pkg::LevelW-1:0] level_q;
  logic [DivW:0]               trial;
  logic [DivW:0]               diff;
  logic                        ge;
  logic                        take;
  logic                        load;

  assign trial = {rem_q, quo_q[QuoW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = (trial >= {1'b0, dvs_q});

  assign take      = res_pop_i && res_vld_q;
  assign load      = (state_q == ST_DONE) && (!res_vld_q || take);
  assign job_pop_o = (state_q == ST_IDLE) && job_valid_i;

  assign res_empty_o     = !res_vld_q;
  assign level_o         = level_q;
  assign status_o.idle   = (state_q == ST_IDLE);
  assign status_o.finish = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      if (load) begin
        res_vld_q <= 1'b1;
      end else if (take) begin
        res_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            cnt_q   <= CntW'(QuoW);
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          cnt_q <= cnt_q - CntW'(1);
          if (cnt_q == CntW'(1)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      quo_q <= QuoW'(job_sum_i) << FRAC_BITS;
      rem_q <= '0;
      dvs_q <= job_div_i;
    end else if (state_q == ST_RUN) begin
      quo_q <= {quo_q[QuoW-2:0], ge};
      rem_q <= ge ? diff[DivW-1:0] : trial[DivW-1:0];
    end
    if (load) begin
      level_q <= mald_pkg::LevelW'(quo_q);
    end
  end

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench of the mean absolute level decimator
// A directed table covers the sample formats, the unused format code, clamped
// channel and block sizes and a full-scale block. Random register settings
// and samples follow, under changing idle patterns on both queue sides. Every
// level is checked against a level predictor kept inside this bench.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Random samples to send before the run winds down.
  localparam int unsigned RandItems  = 1600;
  // Cycles to let pass before a register write.
  localparam int unsigned DrainCycles = 64;
  // Cycles without any accepted item or register write before giving up.
  localparam int unsigned StallLimit = 4000;
  // Only the first few failures are printed.
  localparam int unsigned ShownFails = 10;

  // The format code that the package leaves unnamed; such samples count as zero.
  localparam logic [mald_pkg::FmtW-1:0] FmtUnused = 2'd3;

  typedef enum logic {
    ROW_CFG    = 1'b0,
    ROW_SAMPLE = 1'b1
  } row_kind_e;

  // One row of the directed table. A register row writes value to reg_idx. A
  // sample row pushes value. Where has_level is set, the level that the
  // sample completes is given by hand instead of being predicted.
  typedef struct packed {
    row_kind_e                     kind;
    mald_pkg::cfg_reg_e            reg_idx;
    logic [mald_pkg::SampleW-1:0]  value;
    logic                          has_level;
    logic [mald_pkg::LevelW-1:0]   level;
  } stim_row_t;

  localparam int NumRows = 24;
  localparam stim_row_t StimRows [NumRows] = '{
    // Defaults are s16 and two channels. One frame per block makes each pair
    // of samples produce a level right away.
    '{ROW_CFG,    mald_pkg::REG_BLOCK_SIZE,    32'd1,          1'b0, 40'd0},
    // Largest positive s16 sample twice. The upper bits must be ignored.
    '{ROW_SAMPLE, mald_pkg::REG_SAMPLE_FORMAT, 32'h0000_7fff,  1'b0, 40'd0},
    '{ROW_SAMPLE, mald_pkg::REG_SAMPLE_FORMAT, 32'hffff_7fff,  1'b1, 40'd8388352},
    // Most negative s16 sample twice. The magnitude of the sum is taken.
    '{ROW_SAMPLE, mald_pkg::REG_SAMPLE_FORMAT, 32'h0000_8000,  1'b0, 40'd0},
    '{ROW_SAMPLE, mald_pkg::REG_SAMPLE_FORMAT, 32'h1234_8000,  1'b1, 40'd8388608},
    // Opposite samples cancel within the frame before the magnitude is taken.
    '{ROW_SAMPLE, mald_pkg::REG_SAMPLE_FORMAT, 32'h0000_0005,  1'b0, 40'd0},
    '{ROW_SAMPLE, mald_pkg::REG_SAMPLE_FORMAT, 32'h0000_fffb,  1'b1, 40'd0},
    // The u8 format is not centered. A channel count of zero acts as one.
    '{ROW_CFG,    mald_pkg::REG_SAMPLE_FORMAT, 32'(mald_pkg::FMT_U8), 1'b0, 40'd0},
    '{ROW_CFG,    mald_pkg::REG_CHANNEL_COUNT, 32'd0,          1'b0, 40'd0},
    '{ROW_SAMPLE, mald_pkg::REG_SAMPLE_FORMAT, 32'hffff_ff80,  1'b1, 40'd32768},
    '{ROW_SAMPLE, mald_pkg::REG_SAMPLE_FORMAT, 32'h0000_00ff,  1'b1, 40'd65280},
    // Under the unused format code, every sample counts as zero.
    '{ROW_CFG,    mald_pkg::REG_SAMPLE_FORMAT, 32'(FmtUnused), 1'b0, 40'd0},
    '{ROW_SAMPLE, mald_pkg::REG_SAMPLE_FORMAT, 32'hdead_beef,  1'b1, 40'd0},
    // s32 format, with a channel count above the maximum (it acts as eight)
    // and a block size of zero (it acts as one). Eight most-negative samples
    // give the largest level the block can emit.
    '{ROW_CFG,    mald_pkg::REG_SAMPLE_FORMAT, 32'(mald_pkg::FMT_S32), 1'b0, 40'd0},
    '{ROW_CFG,    mald_pkg::REG_CHANNEL_COUNT, 32'd15,         1'b0, 40'd0},
    '{ROW_CFG,    mald_pkg::REG_BLOCK_SIZE,    32'd0,          1'b0, 40'd0},
    '{ROW_SAMPLE, mald_pkg::REG_SAMPLE_FORMAT, 32'h8000_0000,  1'b0, 40'd0},
    '{ROW_SAMPLE, mald_pkg::REG_SAMPLE_FORMAT, 32'h8000_0000,  1'b0, 40'd0},
    '{ROW_SAMPLE, mald_pkg::REG_SAMPLE_FORMAT, 32'h8000_0000,  1'b0, 40'd0},
    '{ROW_SAMPLE, mald_pkg::REG_SAMPLE_FORMAT, 32'h8000_0000,  1'b0, 40'd0},
    '{ROW_SAMPLE, mald_pkg::REG_SAMPLE_FORMAT, 32'h8000_0000,  1'b0, 40'd0},
    '{ROW_SAMPLE, mald_pkg::REG_SAMPLE_FORMAT, 32'h8000_0000,  1'b0, 40'd0},
    '{ROW_SAMPLE, mald_pkg::REG_SAMPLE_FORMAT, 32'h8000_0000,  1'b0, 40'd0},
    '{ROW_SAMPLE, mald_pkg::REG_SAMPLE_FORMAT, 32'h8000_0000,  1'b1, 40'h80_0000_0000}
  };

  // Full-scale and boundary samples. Random phases mix these in.
  localparam logic [mald_pkg::SampleW-1:0] Extremes [7] = '{
    32'h8000_0000, 32'h7fff_ffff, 32'hffff_8000, 32'h0000_7fff,
    32'h0000_00ff, 32'h0000_0000, 32'hffff_ffff
  };

  logic                          clk_i;
  logic                          rst_ni;
  logic                          push;
  logic                          full;
  logic [mald_pkg::SampleW-1:0]  sample_bits_i;
  logic                          empty;
  logic                          pop;
  logic [mald_pkg::LevelW-1:0]   level_o;
  logic                          cfg_we_i;
  logic [mald_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [mald_pkg::CfgW-1:0]     cfg_data_i;

  // Register copies and accumulators of the level predictor.
  logic [mald_pkg::FmtW-1:0]     fmt_reg;
  logic [mald_pkg::ChCfgW-1:0]   chan_reg;
  logic [mald_pkg::BkCfgW-1:0]   block_reg;
  logic signed [63:0]            frame_acc;
  int unsigned                   chan_idx;
  logic [63:0]                   block_acc;
  int unsigned                   frames_done;

  // Levels that the predictor expects, oldest first.
  logic [mald_pkg::LevelW-1:0]   pending_levels [$];
  logic [mald_pkg::LevelW-1:0]   want_level;

  int unsigned snd_idle_pct;
  int unsigned rcv_idle_pct;
  int unsigned samples_sent;
  int unsigned levels_seen;
  int unsigned reg_writes;
  int unsigned fail_count;
  int unsigned stall_count;

  mean_abs_level_decimator_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .sample_bits_i (sample_bits_i),
    .empty         (empty),
    .pop           (pop),
    .level_o       (level_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Out-of-range channel and block settings are clamped into 1..hi.
  function automatic int unsigned clamp_setting(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic signed [63:0] decode_sample(
      input logic [mald_pkg::SampleW-1:0] raw);
    case (fmt_reg)
      mald_pkg::FMT_U8:  return {56'd0, raw[7:0]};
      mald_pkg::FMT_S16: return {{48{raw[15]}}, raw[15:0]};
      mald_pkg::FMT_S32: return {{32{raw[31]}}, raw};
      default:           return '0;
    endcase
  endfunction

  // Takes one sample into the predictor. It returns 1 when the sample closes
  // a block, and then lvl holds the level that the block emits.
  function automatic bit level_after_sample(input logic [mald_pkg::SampleW-1:0] raw,
                                            output logic [mald_pkg::LevelW-1:0] lvl);
    int unsigned chans;
    int unsigned frames;
    logic [63:0] mag;
    logic [63:0] divisor;
    logic [63:0] quot;
    chans  = clamp_setting(chan_reg, mald_pkg::MaxChannels);
    frames = clamp_setting(block_reg, mald_pkg::MaxBlock);
    lvl = '0;
    frame_acc += decode_sample(raw);
    if (chan_idx + 1 < chans) begin
      chan_idx++;
      return 1'b0;
    end
    mag = (frame_acc < 0) ? -frame_acc : frame_acc;
    block_acc += mag;
    frame_acc = '0;
    chan_idx = 0;
    if (frames_done + 1 < frames) begin
      frames_done++;
      return 1'b0;
    end
    divisor = 64'(chans) * 64'(frames);
    quot = (block_acc << mald_pkg::FracBits) / divisor;
    lvl = quot[mald_pkg::LevelW-1:0];
    block_acc = '0;
    frames_done = 0;
    return 1'b1;
  endfunction

  task automatic note_failure(input string what,
                              input logic [mald_pkg::LevelW-1:0] exp_level,
                              input logic [mald_pkg::LevelW-1:0] got_level);
    fail_count++;
    if (fail_count <= ShownFails) begin
      $display("%t: %s: expected level %0d, got %0d", $realtime, what, exp_level, got_level);
    end
  endtask

  // All tasks below start and end at a falling clock edge.
  task automatic send_sample(input logic [mald_pkg::SampleW-1:0] s, input bit typed,
                             input logic [mald_pkg::LevelW-1:0] typed_level);
    logic [mald_pkg::LevelW-1:0] lvl;
    bit got;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    sample_bits_i <= s;
    do @(posedge clk_i); while (full);
    got = level_after_sample(s, lvl);
    if (typed) lvl = typed_level;
    if (got || typed) pending_levels = {pending_levels, lvl};
    samples_sent++;
    @(negedge clk_i);
  endtask

  // Registers are only written once every expected level has been taken and
  // the tail of the last block has had time to settle.
  task automatic wait_drained();
    push <= 1'b0;
    while (pending_levels.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input mald_pkg::cfg_reg_e idx,
                           input logic [mald_pkg::CfgW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    case (idx)
      mald_pkg::REG_SAMPLE_FORMAT: fmt_reg   = data[mald_pkg::FmtW-1:0];
      mald_pkg::REG_CHANNEL_COUNT: chan_reg  = data[mald_pkg::ChCfgW-1:0];
      default:                     block_reg = data[mald_pkg::BkCfgW-1:0];
    endcase
    reg_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // The result side is a plain queue. Pop is driven at the falling edge and a
  // level counts as taken at the rising edge where pop is high and empty low.
  always @(negedge clk_i) begin
    pop <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      levels_seen++;
      if (pending_levels.size() == 0) begin
        note_failure("level with no block behind it", '0, level_o);
      end else begin
        want_level = pending_levels.pop_front();
        if (level_o !== want_level) note_failure("level mismatch", want_level, level_o);
      end
    end
  end

  // The watchdog counts cycles in which nothing moves on any port.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty) || cfg_we_i) begin
        stall_count <= 0;
      end else if (stall_count >= StallLimit) begin
        $display("Watchdog: no progress for %0d cycles", StallLimit);
        $display("simulation failed");
        $finish;
      end else begin
        stall_count <= stall_count + 1;
      end
    end
  end

  initial begin
    int unsigned rand_start;
    int unsigned phase_len;
    bit loud;
    bit wrote;
    logic [mald_pkg::SampleW-1:0] loud_value;
    logic [mald_pkg::SampleW-1:0] s;

    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    push          = 1'b0;
    sample_bits_i = '0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    fmt_reg       = mald_pkg::FmtReset;
    chan_reg      = mald_pkg::ChReset;
    block_reg     = mald_pkg::BkReset;
    frame_acc     = '0;
    chan_idx      = 0;
    block_acc     = '0;
    frames_done   = 0;
    samples_sent  = 0;
    reg_writes    = 0;
    snd_idle_pct  = 7;
    rcv_idle_pct  = 84;

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part. The sender stalls rarely here and the receiver often.
    foreach (StimRows[i]) begin
      if (StimRows[i].kind == ROW_CFG) begin
        wait_drained();
        write_reg(StimRows[i].reg_idx, mald_pkg::CfgW'(StimRows[i].value));
      end else begin
        send_sample(StimRows[i].value, StimRows[i].has_level, StimRows[i].level);
      end
    end

    // Random part. Each phase starts from a drained block and rewrites some
    // registers. A partial block is left behind on purpose, so the new
    // settings also take effect in the middle of a block. The first phase
    // writes every register.
    rand_start = samples_sent;
    while (samples_sent - rand_start < RandItems) begin
      case (((samples_sent - rand_start) * 3) / RandItems)
        0: begin
          snd_idle_pct = 7;
          rcv_idle_pct = 84;
        end
        1: begin
          snd_idle_pct = 84;
          rcv_idle_pct = 7;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      wait_drained();
      wrote = 1'b0;
      if (reg_writes < 20 || $urandom_range(0, 1) == 0) begin
        write_reg(mald_pkg::REG_SAMPLE_FORMAT, ($urandom_range(0, 9) < 9) ?
                  mald_pkg::CfgW'($urandom_range(0, 2)) : mald_pkg::CfgW'(FmtUnused));
        wrote = 1'b1;
      end
      if (reg_writes < 20 || $urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 9))
          0:       write_reg(mald_pkg::REG_CHANNEL_COUNT, '0);
          1:       write_reg(mald_pkg::REG_CHANNEL_COUNT,
                             mald_pkg::CfgW'($urandom_range(mald_pkg::MaxChannels + 1, 15)));
          default: write_reg(mald_pkg::REG_CHANNEL_COUNT,
                             mald_pkg::CfgW'($urandom_range(1, mald_pkg::MaxChannels)));
        endcase
        wrote = 1'b1;
      end
      if (reg_writes < 20 || !wrote || $urandom_range(0, 1) == 0) begin
        // Block sizes stay small, so that levels come out often.
        case ($urandom_range(0, 19))
          0:       write_reg(mald_pkg::REG_BLOCK_SIZE, '0);
          1:       write_reg(mald_pkg::REG_BLOCK_SIZE, mald_pkg::CfgW'($urandom_range(17, 64)));
          default: write_reg(mald_pkg::REG_BLOCK_SIZE, mald_pkg::CfgW'($urandom_range(1, 16)));
        endcase
      end
      // Some phases hold one boundary value, which drives the sums to their
      // limits. The others mix boundary values with fully random words.
      loud = ($urandom_range(0, 4) == 0);
      loud_value = Extremes[$urandom_range(0, 6)];
      phase_len = $urandom_range(20, 120);
      repeat (phase_len) begin
        if (loud) s = loud_value;
        else if ($urandom_range(0, 3) == 0) s = Extremes[$urandom_range(0, 6)];
        else s = $urandom;
        send_sample(s, 1'b0, '0);
      end
    end

    // Wait for the last levels, then give a late extra level time to show.
    push <= 1'b0;
    while (pending_levels.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("Sent %0d samples under %0d register writes and checked %0d levels.",
             samples_sent, reg_writes, levels_seen);
    $display("Covered all formats, clamped channel and block sizes and a full-scale block.");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d failures", fail_count);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
